[src/sqrd_pkg.sv]
// Shared types and constants for the signed quotient/remainder divider.
// No dependencies; imported by sqrd_iter and the top level.
package sqrd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH) + 1;

    typedef logic        [DATA_WIDTH-1:0] data_t;
    typedef logic signed [DATA_WIDTH-1:0] sdata_t;
    typedef logic        [CNT_W-1:0]      cnt_t;

    localparam data_t SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAG,
        S_DIV,
        S_FIX
    } state_t;

    // Status of the iterative unit toward the sequencer.
    typedef struct packed {
        logic done;
    } iter_stat_t;

endpackage

[src/sqrd_iter.sv]
// Radix-2 restoring division unit over unsigned magnitudes.
// Depends on sqrd_pkg.
module sqrd_iter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sqrd_pkg::data_t     dividend_mag,
    input  sqrd_pkg::data_t     divisor_mag,
    output sqrd_pkg::iter_stat_t stat,
    output sqrd_pkg::data_t     quot_mag,
    output sqrd_pkg::data_t     rem_mag
);
    import sqrd_pkg::*;

    // quo_reg shifts dividend bits out at the top and quotient bits in at the bottom.
    data_t rem_reg, rem_next;
    data_t quo_reg, quo_next;
    data_t dsr_reg, dsr_next;
    cnt_t  cnt_reg, cnt_next;
    logic  busy_reg, busy_next;
    logic  done_reg, done_next;

    logic [DATA_WIDTH:0] trial;
    logic [DATA_WIDTH:0] diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend_mag;
            dsr_next  = divisor_mag;
            cnt_next  = cnt_t'(DATA_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Keep the difference only when no borrow occurred.
            if (!diff[DATA_WIDTH])
            begin
                rem_next = diff[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - cnt_t'(1);
            if (cnt_reg == cnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.done = done_reg;
    assign quot_mag  = quo_reg;
    assign rem_mag   = rem_reg;

endmodule

[src/signed_quotient_remainder_divider_core.sv]
// Top level of the signed truncating divider: sequencer, sign handling, output register.
// Depends on sqrd_pkg and sqrd_iter.

// Each word on the request side carries a signed dividend and divisor; each word on the
// response side carries the quotient truncated toward zero, the remainder with the
// dividend's sign, and a status code (ok, divide by zero, quotient overflow). An item
// passes from acceptance to a loaded response in these steps: the sequencer forms
// operand magnitudes, the radix-2 restoring unit produces one quotient bit per cycle,
// the sequencer sees the unit's done flag, and it finishes the sign and loads the
// output once the output register is free. The divider then returns to idle with
// req_ready high. A zero divisor skips the iterations. The divider works on one item
// at a time; req_ready is high while it is idle. A finished response waits in the
// output register, so a new request is taken while the response is still held by a
// stalled consumer. A most-negative dividend over minus one saturates the quotient to
// the largest positive value with a zero remainder and the overflow code.
module signed_quotient_remainder_divider_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  sqrd_pkg::sdata_t    dividend,
    input  sqrd_pkg::sdata_t    divisor,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output sqrd_pkg::sdata_t    quotient,
    output sqrd_pkg::sdata_t    remainder,
    output logic [1:0]          status
);
    import sqrd_pkg::*;

    state_t state_reg, state_next;

    // Raw operands, held for the whole item.
    data_t a_reg, a_next;
    data_t b_reg, b_next;

    // Output register.
    logic    out_valid_reg, out_valid_next;
    data_t   q_reg, q_next;
    data_t   r_reg, r_next;
    status_t st_reg, st_next;

    logic       iter_start;
    data_t      a_mag;
    data_t      b_mag;
    iter_stat_t iter_stat;
    data_t      qm;
    data_t      rm;

    logic a_neg;
    logic q_neg;
    logic b_zero;

    assign a_neg  = a_reg[DATA_WIDTH-1];
    assign q_neg  = a_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1];
    assign b_zero = (b_reg == '0);

    // Two's complement magnitudes; the most negative value maps to 2^(W-1) unsigned.
    assign a_mag = a_reg[DATA_WIDTH-1] ? (~a_reg + data_t'(1)) : a_reg;
    assign b_mag = b_reg[DATA_WIDTH-1] ? (~b_reg + data_t'(1)) : b_reg;

    sqrd_iter u_iter (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (iter_start),
        .dividend_mag (a_mag),
        .divisor_mag  (b_mag),
        .stat         (iter_stat),
        .quot_mag     (qm),
        .rem_mag      (rm)
    );

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        st_next        = st_reg;
        iter_start     = 1'b0;
        req_ready      = 1'b0;

        // Drop the held response once the consumer takes it.
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    a_next     = data_t'(dividend);
                    b_next     = data_t'(divisor);
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                // Skip the iterations for a zero divisor.
                if (b_zero)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    iter_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (iter_stat.done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (b_zero)
                    begin
                        q_next  = '0;
                        r_next  = '0;
                        st_next = STATUS_DIV_ZERO;
                    end
                    else
                    begin
                        if (!q_neg && qm[DATA_WIDTH-1])
                        begin
                            q_next  = SAT_MAX;
                            st_next = STATUS_OVERFLOW;
                        end
                        else
                        begin
                            q_next  = q_neg ? (~qm + data_t'(1)) : qm;
                            st_next = STATUS_OK;
                        end
                        r_next = a_neg ? (~rm + data_t'(1)) : rm;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        q_reg  <= q_next;
        r_reg  <= r_next;
        st_reg <= st_next;
    end

    assign rsp_valid = out_valid_reg;
    assign quotient  = sdata_t'(q_reg);
    assign remainder = sdata_t'(r_reg);
    assign status    = st_reg;

endmodule
